>>> rtl/core/wrnhs_pkg.sv
// Package for the weighted random next hop select unit.
// Sizes and command codes shared by the top level and the testbench; no dependencies.
`default_nettype none
package wrnhs_pkg;
    localparam int MAX_CANDIDATES = 16;
    localparam int FIELD_W        = 16;
    localparam int INDEX_OUT_W    = 4;
    localparam int IDX_W          = (MAX_CANDIDATES > 2) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
    localparam int TOTAL_W        = $clog2(MAX_CANDIDATES * 65535 + 1);
    localparam int TARGET_W       = TOTAL_W + FIELD_W;
    localparam int ENTRY_W        = 2 * FIELD_W;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PICK = 1'b1;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [TOTAL_W-1:0]  total_t;
    typedef logic [TARGET_W-1:0] target_t;
endpackage
`default_nettype wire

>>> rtl/core/weighted_random_next_hop_select_unit.sv
// Load request: no result; the unit stays idle and can take another load.
// Pick request: r * total formed at accept, then one candidate per cycle from the store RAM;
// result registered when the chosen entry (or the last) is scanned, no_route result in the cycle after accept.
// Loads are taken one per cycle while idle; no request is taken until a pick's scan ends.
// Reset (rst_n low, async): candidate set empty, total and dropped flag cleared, no result.
// Uses wrnhs_pkg and wrnhs_ram.
`default_nettype none
module weighted_random_next_hop_select_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 cmd,
    input  wire logic [wrnhs_pkg::FIELD_W-1:0]        weight,
    input  wire logic [wrnhs_pkg::FIELD_W-1:0]        hop_id,
    input  wire logic [wrnhs_pkg::FIELD_W-1:0]        random_fraction,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic      [wrnhs_pkg::FIELD_W-1:0]        chosen_hop,
    output logic      [wrnhs_pkg::INDEX_OUT_W-1:0]    chosen_index,
    output logic                                      no_route,
    output logic                                      overflowed
);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                 state_reg, state_next;
    wrnhs_pkg::cnt_t      count_reg, count_next;
    wrnhs_pkg::total_t    total_reg, total_next;
    logic                 dropped_reg, dropped_next;
    wrnhs_pkg::idx_t      idx_reg, idx_next;
    wrnhs_pkg::idx_t      last_reg, last_next;
    wrnhs_pkg::total_t    prefix_reg, prefix_next;
    wrnhs_pkg::target_t   target_reg, target_next;
    logic                 ovf_reg, ovf_next;

    logic                                   out_valid_reg, out_valid_next;
    logic [wrnhs_pkg::FIELD_W-1:0]          hop_reg, hop_next;
    logic [wrnhs_pkg::INDEX_OUT_W-1:0]      index_reg, index_next;
    logic                                   no_route_reg, no_route_next;
    logic                                   ovfl_out_reg, ovfl_out_next;

    logic                                   accept;
    logic                                   slot_free;
    logic                                   ram_we;
    wrnhs_pkg::idx_t                        rd_addr;
    logic [wrnhs_pkg::ENTRY_W-1:0]          rd_data;
    logic [wrnhs_pkg::FIELD_W-1:0]          rd_weight;
    logic [wrnhs_pkg::FIELD_W-1:0]          rd_hop;
    wrnhs_pkg::total_t                      prefix_sum;
    logic                                   hit;
    logic                                   at_last;
    logic                                   full;

    wrnhs_ram #(
        .WIDTH(wrnhs_pkg::ENTRY_W),
        .DEPTH(wrnhs_pkg::MAX_CANDIDATES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[wrnhs_pkg::IDX_W-1:0]),
        .wdata({weight, hop_id}),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && ((cmd == wrnhs_pkg::CMD_LOAD) || slot_free);
    assign accept    = in_valid && in_ready;
    assign full      = (count_reg >= wrnhs_pkg::CNT_W'(wrnhs_pkg::MAX_CANDIDATES));
    assign ram_we    = accept && (cmd == wrnhs_pkg::CMD_LOAD) && !full;

    assign rd_addr    = (state_reg == ST_IDLE) ? '0 : idx_reg + wrnhs_pkg::IDX_W'(1);
    assign rd_weight  = rd_data[wrnhs_pkg::ENTRY_W-1:wrnhs_pkg::FIELD_W];
    assign rd_hop     = rd_data[wrnhs_pkg::FIELD_W-1:0];
    assign prefix_sum = prefix_reg + wrnhs_pkg::TOTAL_W'(rd_weight);
    assign hit        = target_reg <= {prefix_sum, wrnhs_pkg::FIELD_W'(0)};
    assign at_last    = (idx_reg == last_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        dropped_next   = dropped_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        prefix_next    = prefix_reg;
        target_next    = target_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hop_next       = hop_reg;
        index_next     = index_reg;
        no_route_next  = no_route_reg;
        ovfl_out_next  = ovfl_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == wrnhs_pkg::CMD_LOAD)
                    begin
                        if (full)
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + wrnhs_pkg::CNT_W'(1);
                            total_next = total_reg + wrnhs_pkg::TOTAL_W'(weight);
                        end
                    end
                    else
                    begin
                        count_next   = '0;
                        total_next   = '0;
                        dropped_next = 1'b0;
                        if ((count_reg == '0) || (total_reg == '0))
                        begin
                            out_valid_next = 1'b1;
                            hop_next       = '0;
                            index_next     = '0;
                            no_route_next  = 1'b1;
                            ovfl_out_next  = dropped_reg;
                        end
                        else
                        begin
                            // r * total against prefix << 16, one entry per cycle
                            target_next = wrnhs_pkg::TARGET_W'(random_fraction)
                                          * wrnhs_pkg::TARGET_W'(total_reg);
                            last_next   = wrnhs_pkg::IDX_W'(count_reg - wrnhs_pkg::CNT_W'(1));
                            idx_next    = '0;
                            prefix_next = '0;
                            ovf_next    = dropped_reg;
                            state_next  = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                prefix_next = prefix_sum;
                if (hit || at_last)
                begin
                    out_valid_next = 1'b1;
                    hop_next       = rd_hop;
                    index_next     = wrnhs_pkg::INDEX_OUT_W'(32'(idx_reg));
                    no_route_next  = 1'b0;
                    ovfl_out_next  = ovf_reg;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + wrnhs_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        prefix_reg   <= prefix_next;
        target_reg   <= target_next;
        ovf_reg      <= ovf_next;
        hop_reg      <= hop_next;
        index_reg    <= index_next;
        no_route_reg <= no_route_next;
        ovfl_out_reg <= ovfl_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign chosen_hop   = hop_reg;
    assign chosen_index = index_reg;
    assign no_route     = no_route_reg;
    assign overflowed   = ovfl_out_reg;
endmodule
`default_nettype wire

>>> rtl/core/wrnhs_ram.sv
// Generic single write port RAM with registered read.
// Standalone; no package dependency.
`default_nettype none
module wrnhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> sim/weighted_random_next_hop_select_unit_tb.sv
// Testbench for weighted_random_next_hop_select_unit: directed and random load/pick requests.
// Routes come from directed rows or an in-bench roulette model; compared field by field.
// Depends on wrnhs_pkg and the RTL top level only.
`timescale 1ns / 1ps
module weighted_random_next_hop_select_unit_tb;

    localparam int RANDOM_REQUESTS = 525;

    typedef struct packed {
        logic [wrnhs_pkg::FIELD_W-1:0]     hop;
        logic [wrnhs_pkg::INDEX_OUT_W-1:0] index;
        logic                              no_route;
        logic                              overflowed;
    } route_t;

    typedef struct {
        logic                          op;
        logic [wrnhs_pkg::FIELD_W-1:0] w;
        logic [wrnhs_pkg::FIELD_W-1:0] h;
        logic [wrnhs_pkg::FIELD_W-1:0] r;
        logic                          known;
        route_t                        want;
    } stim_row_t;

    logic                              clk;
    logic                              rst_n           = 1'b0;
    logic                              in_valid        = 1'b0;
    logic                              in_ready;
    logic                              cmd             = wrnhs_pkg::CMD_LOAD;
    logic [wrnhs_pkg::FIELD_W-1:0]     weight          = '0;
    logic [wrnhs_pkg::FIELD_W-1:0]     hop_id          = '0;
    logic [wrnhs_pkg::FIELD_W-1:0]     random_fraction = '0;
    logic                              out_valid;
    logic                              out_ready       = 1'b0;
    logic [wrnhs_pkg::FIELD_W-1:0]     chosen_hop;
    logic [wrnhs_pkg::INDEX_OUT_W-1:0] chosen_index;
    logic                              no_route;
    logic                              overflowed;

    // expected route for a pick row whose answer is written into the table
    logic                              row_known       = 1'b0;
    route_t                            row_want        = '0;

    // predictor state
    logic [wrnhs_pkg::FIELD_W-1:0]     weight_mem [wrnhs_pkg::MAX_CANDIDATES];
    logic [wrnhs_pkg::FIELD_W-1:0]     hop_mem [wrnhs_pkg::MAX_CANDIDATES];
    wrnhs_pkg::cnt_t                   set_count       = '0;
    wrnhs_pkg::total_t                 set_total       = '0;
    logic                              dropped         = 1'b0;

    route_t                            route_q [$];
    stim_row_t                         directed_q [$];

    int                                sender_idle_pct = 22;
    int                                stall_pct       = 49;
    int                                mismatches      = 0;
    int                                requests_sent   = 0;
    int                                loads_seen      = 0;
    int                                picks_seen      = 0;
    int                                routes_checked  = 0;
    int                                no_route_seen   = 0;
    int                                overflow_seen   = 0;

    weighted_random_next_hop_select_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .weight          (weight),
        .hop_id          (hop_id),
        .random_fraction (random_fraction),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chosen_hop      (chosen_hop),
        .chosen_index    (chosen_index),
        .no_route        (no_route),
        .overflowed      (overflowed)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic route_t roulette_choice(input logic [wrnhs_pkg::FIELD_W-1:0] r);
        route_t             res;
        wrnhs_pkg::target_t target;
        wrnhs_pkg::total_t  prefix;
        logic               found;
        res            = '0;
        res.overflowed = dropped;
        if (set_count == 0 || set_total == 0)
        begin
            res.no_route = 1'b1;
        end
        else
        begin
            target    = wrnhs_pkg::target_t'(r) * wrnhs_pkg::target_t'(set_total);
            prefix    = '0;
            found     = 1'b0;
            res.index = wrnhs_pkg::INDEX_OUT_W'(set_count - 1);
            res.hop   = hop_mem[set_count - 1];
            for (int i = 0; i < set_count; i++)
            begin
                prefix = prefix + weight_mem[i];
                if (!found && target <= {prefix, {wrnhs_pkg::FIELD_W{1'b0}}})
                begin
                    found     = 1'b1;
                    res.index = wrnhs_pkg::INDEX_OUT_W'(i);
                    res.hop   = hop_mem[i];
                end
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input route_t exp_r, input route_t got_r);
        mismatches++;
        if (mismatches <= 10)
            $display({"[%0t] %s: expected hop=%h idx=%0d no_route=%b ovf=%b",
                      " / got hop=%h idx=%0d no_route=%b ovf=%b"},
                     $time, what, exp_r.hop, exp_r.index, exp_r.no_route, exp_r.overflowed,
                     got_r.hop, got_r.index, got_r.no_route, got_r.overflowed);
    endtask

    always @(posedge clk)
    begin : route_check
        route_t got;
        route_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {chosen_hop, chosen_index, no_route, overflowed};
                if (route_q.size() == 0)
                begin
                    flag_mismatch("route with no pick pending", '0, got);
                end
                else
                begin
                    want = route_q.pop_front();
                    routes_checked++;
                    if (want.no_route)
                        no_route_seen++;
                    if (want.overflowed)
                        overflow_seen++;
                    if (got.hop !== want.hop || got.index !== want.index ||
                        got.no_route !== want.no_route || got.overflowed !== want.overflowed)
                        flag_mismatch("route mismatch", want, got);
                end
            end
            if (in_valid && in_ready)
            begin
                if (cmd == wrnhs_pkg::CMD_LOAD)
                begin
                    loads_seen++;
                    if (set_count < wrnhs_pkg::MAX_CANDIDATES)
                    begin
                        weight_mem[set_count] = weight;
                        hop_mem[set_count]    = hop_id;
                        set_count             = set_count + 1'b1;
                        set_total             = set_total + weight;
                    end
                    else
                    begin
                        dropped = 1'b1;
                    end
                end
                else
                begin
                    picks_seen++;
                    want = roulette_choice(random_fraction);
                    route_q.push_back(row_known ? row_want : want);
                    set_count = '0;
                    set_total = '0;
                    dropped   = 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input stim_row_t row);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= row.op;
        weight          <= row.w;
        hop_id          <= row.h;
        random_fraction <= row.r;
        row_known       <= row.known;
        row_want        <= row.want;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic drain_routes;
        in_valid <= 1'b0;
        @(negedge clk);
        while (route_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        stim_row_t row;
        int        n;
        int        phase_end;
        logic      zero_set;

        // empty set, then a zero total
        directed_q.push_back('{wrnhs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                               route_t'({16'h0000, 4'h0, 1'b1, 1'b0})});
        directed_q.push_back('{wrnhs_pkg::CMD_LOAD, 16'h0000, 16'h1234, 16'h0000, 1'b0, '0});
        directed_q.push_back('{wrnhs_pkg::CMD_PICK, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b1,
                               route_t'({16'h0000, 4'h0, 1'b1, 1'b0})});
        // zero-weight first candidate with r = 0 is chosen
        directed_q.push_back('{wrnhs_pkg::CMD_LOAD, 16'h0000, 16'hAAAA, 16'hFFFF, 1'b0, '0});
        directed_q.push_back('{wrnhs_pkg::CMD_LOAD, 16'hFFFF, 16'h5555, 16'h0000, 1'b0, '0});
        directed_q.push_back('{wrnhs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                               route_t'({16'hAAAA, 4'h0, 1'b0, 1'b0})});
        // full set at max weight, one dropped load, r at max picks the last entry
        for (int i = 0; i < wrnhs_pkg::MAX_CANDIDATES; i++)
            directed_q.push_back('{wrnhs_pkg::CMD_LOAD, 16'hFFFF,
                                   wrnhs_pkg::FIELD_W'(16'hFFF0 + i), 16'h0000, 1'b0, '0});
        directed_q.push_back('{wrnhs_pkg::CMD_LOAD, 16'h1234, 16'h0000, 16'h0000, 1'b0, '0});
        directed_q.push_back('{wrnhs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'hFFFF, 1'b1,
                               route_t'({16'hFFFF, 4'hF, 1'b0, 1'b1})});
        // dropped flag is cleared by the pick
        directed_q.push_back('{wrnhs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                               route_t'({16'h0000, 4'h0, 1'b1, 1'b0})});

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_q[i])
            send_request(directed_q[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 22; stall_pct = 49; end
                1: begin sender_idle_pct = 49; stall_pct = 22; end
                default: begin sender_idle_pct = 0; stall_pct = 0; end
            endcase
            phase_end = requests_sent + RANDOM_REQUESTS / 3;
            while (requests_sent < phase_end)
            begin
                case ($urandom_range(0, 19))
                    0:       n = 0;
                    1, 2:    n = $urandom_range(wrnhs_pkg::MAX_CANDIDATES + 1,
                                                wrnhs_pkg::MAX_CANDIDATES + 4);
                    3, 4, 5: n = $urandom_range(1, 3);
                    default: n = $urandom_range(1, wrnhs_pkg::MAX_CANDIDATES);
                endcase
                zero_set = ($urandom_range(0, 9) == 0);
                for (int j = 0; j < n; j++)
                begin
                    row.op    = wrnhs_pkg::CMD_LOAD;
                    row.h     = wrnhs_pkg::FIELD_W'($urandom);
                    row.r     = wrnhs_pkg::FIELD_W'($urandom);
                    row.known = 1'b0;
                    row.want  = '0;
                    case ($urandom_range(0, 7))
                        0:       row.w = 16'h0000;
                        1:       row.w = 16'hFFFF;
                        2:       row.w = wrnhs_pkg::FIELD_W'($urandom_range(0, 15));
                        default: row.w = wrnhs_pkg::FIELD_W'($urandom);
                    endcase
                    if (zero_set)
                        row.w = 16'h0000;
                    send_request(row);
                end
                row.op    = wrnhs_pkg::CMD_PICK;
                row.w     = wrnhs_pkg::FIELD_W'($urandom);
                row.h     = wrnhs_pkg::FIELD_W'($urandom);
                row.known = 1'b0;
                row.want  = '0;
                case ($urandom_range(0, 7))
                    0:       row.r = 16'h0000;
                    1:       row.r = 16'hFFFF;
                    default: row.r = wrnhs_pkg::FIELD_W'($urandom);
                endcase
                send_request(row);
            end
            drain_routes();
        end

        repeat (40) @(negedge clk);
        $display("Ran %0d requests (%0d loads, %0d picks) over three idle/stall mixes.",
                 requests_sent, loads_seen, picks_seen);
        $display("Checked %0d routes: %0d with no route, %0d with dropped loads; %0d mismatches.",
                 routes_checked, no_route_seen, overflow_seen, mismatches);
        if (mismatches == 0 && route_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d routes outstanding.", route_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/wrnhs_pkg.sv
rtl/core/wrnhs_ram.sv
rtl/core/weighted_random_next_hop_select_unit.sv
sim/weighted_random_next_hop_select_unit_tb.sv
